### src/cpt_pkg.sv
// Package with types and constants shared by the cover position tracker.
package cpt_pkg;

    localparam int unsigned POS_W = 7;
    localparam int unsigned TGT_W = 8;
    localparam int unsigned CNT_W = 16;
    localparam logic [POS_W-1:0] TOP_POSITION = 7'd100;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic CFG_IDX_STEP_INTERVAL = 1'b0;
    localparam logic CFG_IDX_REPORT_HOLDOFF = 1'b1;
    localparam logic [CNT_W-1:0] STEP_INTERVAL_RST = 16'd310;
    localparam logic [CNT_W-1:0] REPORT_HOLDOFF_RST = 16'd1000;

    typedef logic signed [1:0] t_dir;
    localparam t_dir DIR_STOP = 2'sb00;
    localparam t_dir DIR_INC = 2'sb01;
    localparam t_dir DIR_DEC = 2'sb11;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_TARGET = 3'd1,
        CMD_UP     = 3'd2,
        CMD_DOWN   = 3'd3,
        CMD_STOP   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] step_interval;
        logic [CNT_W-1:0] report_holdoff;
    } t_cfg;

    typedef struct packed {
        logic             report_valid;
        logic [POS_W-1:0] position;
        t_dir             direction;
    } t_result;

endpackage

### src/cpt_cfg.sv
// APB register file holding the step interval and the report hold-off.
module cpt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output cpt_pkg::t_cfg                  o_cfg
);
    import cpt_pkg::*;

    logic [CNT_W-1:0] r_step_interval;
    logic [CNT_W-1:0] r_report_holdoff;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval  <= STEP_INTERVAL_RST;
            r_report_holdoff <= REPORT_HOLDOFF_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                CFG_IDX_STEP_INTERVAL:  r_step_interval  <= pwdata[CNT_W-1:0];
                CFG_IDX_REPORT_HOLDOFF: r_report_holdoff <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_IDX_STEP_INTERVAL:  prdata = {16'd0, r_step_interval};
            CFG_IDX_REPORT_HOLDOFF: prdata = {16'd0, r_report_holdoff};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg.step_interval  = r_step_interval;
    assign o_cfg.report_holdoff = r_report_holdoff;

endmodule

### src/cpt_core.sv
// Tracker state and the single-pass update for one command word.
module cpt_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  cpt_pkg::t_cmd             i_cmd,
    input  logic [cpt_pkg::TGT_W-1:0] i_tgt,
    input  cpt_pkg::t_cfg             i_cfg,
    output cpt_pkg::t_result          o_result
);
    import cpt_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    t_dir             r_dir, n_dir;
    logic             r_goal_act, n_goal_act;
    logic [TGT_W-1:0] r_goal, n_goal;
    logic [CNT_W-1:0] r_step_wait, n_step_wait;
    logic [CNT_W-1:0] r_rep_wait, n_rep_wait;
    logic [POS_W-1:0] r_last, n_last;
    logic             n_sent;

    logic             holdoff_done;
    logic [CNT_W-1:0] rep_wait_dec;
    logic [POS_W-1:0] step_pos;
    logic             goal_hit;
    t_dir             step_dir;

    assign holdoff_done = (r_rep_wait == '0);
    assign rep_wait_dec = holdoff_done ? r_rep_wait : r_rep_wait - 1'b1;

    // Position after one step, clamped at both ends.
    always_comb begin
        step_pos = r_pos;
        if (r_dir == DIR_DEC && r_pos != '0) begin
            step_pos = r_pos - 1'b1;
        end else if (r_dir == DIR_INC && r_pos < TOP_POSITION) begin
            step_pos = r_pos + 1'b1;
        end
    end

    assign goal_hit = r_goal_act && (r_goal == {1'b0, step_pos});
    assign step_dir = goal_hit ? DIR_STOP : r_dir;

    always_comb begin
        n_pos       = r_pos;
        n_dir       = r_dir;
        n_goal_act  = r_goal_act;
        n_goal      = r_goal;
        n_step_wait = r_step_wait;
        n_rep_wait  = r_rep_wait;
        n_last      = r_last;
        n_sent      = 1'b0;
        unique case (i_cmd)
            CMD_TICK: begin
                n_rep_wait = rep_wait_dec;
                if (r_step_wait != '0) begin
                    n_step_wait = r_step_wait - 1'b1;
                end else begin
                    n_pos      = step_pos;
                    n_dir      = step_dir;
                    n_goal_act = r_goal_act & ~goal_hit;
                    if (r_last != step_pos && (holdoff_done || step_dir == DIR_STOP)) begin
                        n_last     = step_pos;
                        n_rep_wait = i_cfg.report_holdoff;
                        n_sent     = 1'b1;
                    end
                    n_step_wait = (step_dir != DIR_STOP) ? i_cfg.step_interval : '0;
                end
            end
            CMD_TARGET: begin
                n_goal_act = 1'b1;
                n_goal     = i_tgt;
                if (i_tgt > {1'b0, r_pos}) begin
                    n_dir = DIR_INC;
                end else if (i_tgt < {1'b0, r_pos}) begin
                    n_dir = DIR_DEC;
                end
            end
            CMD_UP:   n_dir = DIR_DEC;
            CMD_DOWN: n_dir = DIR_INC;
            CMD_STOP: begin
                n_dir      = DIR_STOP;
                n_goal_act = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_dir       <= DIR_STOP;
            r_goal_act  <= 1'b0;
            r_goal      <= '0;
            r_step_wait <= '0;
            r_rep_wait  <= '0;
            r_last      <= '0;
        end else if (i_en) begin
            r_pos       <= n_pos;
            r_dir       <= n_dir;
            r_goal_act  <= n_goal_act;
            r_goal      <= n_goal;
            r_step_wait <= n_step_wait;
            r_rep_wait  <= n_rep_wait;
            r_last      <= n_last;
        end
    end

    assign o_result.report_valid = n_sent;
    assign o_result.position     = n_pos;
    assign o_result.direction    = n_dir;

endmodule

### src/cover_position_tracker.sv
// Each accepted word passes the input register, then the tracker update into the output register.
// Throughput: one word per cycle unless the output stalls; the tracker state updates once per word.
// An input register and an output register part the two stream sides.
// Reset (synchronous, active low) stops the cover at position zero, clears
// all timers and the target, and loads the default step interval and hold-off.
module cover_position_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,  // [7:0] target
    input  logic [2:0]                     i_s_tuser,  // [2:0] command
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata,  // [6:0] report_position,
                                                       // [8:7] moving_direction
    output logic [0:0]                     o_m_tuser,  // [0] report_valid
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cpt_pkg::*;

    t_cfg             cfg;
    t_result          result;
    logic             r_in_valid;
    t_cmd             r_in_cmd;
    logic [TGT_W-1:0] r_in_tgt;
    logic             r_out_valid;
    t_result          r_out;
    logic             advance;
    logic             in_accept;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd <= t_cmd'(i_s_tuser);
            r_in_tgt <= i_s_tdata;
        end
    end

    cpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cmd    (r_in_cmd),
        .i_tgt    (r_in_tgt),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.direction, r_out.position};
    assign o_m_tuser  = r_out.report_valid;

    // The cover never passes the top end.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:0] <= TOP_POSITION))
        else $error("reported position above the top end");

    // Direction is one of stop, increasing or decreasing.
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8:7] != 2'b10))
        else $error("illegal direction code");

    // An accepted word is held in the input register next cycle.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted word lost");

    // A finished word always lands in the output register.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result word lost");

endmodule

### tb/tb_cover_position_tracker.sv
// Self-checking testbench for the cover position tracker: stream stimulus, predictor, checks.
module tb_cover_position_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import cpt_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LONG_HOLD = 80;
    localparam int unsigned PRINT_CAP = 50;
    localparam logic [CFG_ADDR_W-1:0] ADDR_STEP_INTERVAL = {CFG_IDX_STEP_INTERVAL, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_REPORT_HOLDOFF = {CFG_IDX_REPORT_HOLDOFF, 2'b00};

    typedef struct packed {
        logic [2:0]       cmd;
        logic [TGT_W-1:0] tgt;
    } t_cover_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // [7:0] target
    logic [2:0]  i_s_tuser = '0;   // [2:0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [6:0] report_position, [8:7] moving_direction
    logic [0:0]  o_m_tuser;        // [0] report_valid
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    cover_position_tracker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // Predicted tracker state and timing registers, starting from their reset values.
    logic [CNT_W-1:0] cfg_step = STEP_INTERVAL_RST;
    logic [CNT_W-1:0] cfg_holdoff = REPORT_HOLDOFF_RST;
    logic [POS_W-1:0] pos = '0;
    t_dir             dir = DIR_STOP;
    logic             goal_on = 1'b0;
    logic [TGT_W-1:0] goal = '0;
    logic [CNT_W-1:0] step_cnt = '0;
    logic [CNT_W-1:0] hold_cnt = '0;
    logic [POS_W-1:0] last_pos = '0;

    t_cover_cmd  cmd_queue[$];
    t_result     pending_reports[$];
    int unsigned n_queued = 0;
    int unsigned n_mismatch = 0;
    int unsigned idle_cycles = 0;
    int unsigned s_gap = 0;
    int unsigned m_stall = 0;
    bit          s_taken = 1'b0;
    bit          m_taken = 1'b0;
    bit          s_eager = 1'b0;
    bit          m_eager = 1'b0;
    bit          hold_req = 1'b0;

    function automatic void track_word(logic [2:0] cmd, logic [TGT_W-1:0] tgt);
        t_result r;
        logic    fired;
        logic    hold_done;
        fired = 1'b0;
        case (cmd)
            CMD_TICK: begin
                hold_done = (hold_cnt == '0);
                if (hold_cnt != '0)
                    hold_cnt = hold_cnt - 1'b1;
                if (step_cnt != '0) begin
                    step_cnt = step_cnt - 1'b1;
                end else begin
                    if (dir == DIR_DEC && pos != '0)
                        pos = pos - 1'b1;
                    else if (dir == DIR_INC && pos < TOP_POSITION)
                        pos = pos + 1'b1;
                    if (goal_on && goal == {1'b0, pos}) begin
                        goal_on = 1'b0;
                        dir = DIR_STOP;
                    end
                    if (last_pos != pos && (hold_done || dir == DIR_STOP)) begin
                        last_pos = pos;
                        hold_cnt = cfg_holdoff;
                        fired = 1'b1;
                    end
                    step_cnt = (dir != DIR_STOP) ? cfg_step : '0;
                end
            end
            CMD_TARGET: begin
                goal_on = 1'b1;
                goal = tgt;
                if (tgt > {1'b0, pos})
                    dir = DIR_INC;
                else if (tgt < {1'b0, pos})
                    dir = DIR_DEC;
            end
            CMD_UP: dir = DIR_DEC;
            CMD_DOWN: dir = DIR_INC;
            CMD_STOP: begin
                dir = DIR_STOP;
                goal_on = 1'b0;
            end
            default: ;
        endcase
        r.report_valid = fired;
        r.position = pos;
        r.direction = dir;
        pending_reports.push_back(r);
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP)
            $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // Check the output side first so that a word never meets its own prediction.
            if (o_m_tvalid && i_m_tready) begin
                m_taken = 1'b1;
                moved = 1'b1;
                if (pending_reports.size() == 0) begin
                    flag_mismatch("result word with nothing pending", 0, o_m_tdata);
                end else begin
                    want = pending_reports.pop_front();
                    if (o_m_tuser[0] !== want.report_valid)
                        flag_mismatch("report_valid", want.report_valid, o_m_tuser[0]);
                    if (o_m_tdata[6:0] !== want.position)
                        flag_mismatch("report_position", want.position, o_m_tdata[6:0]);
                    if (o_m_tdata[8:7] !== want.direction)
                        flag_mismatch("moving_direction", want.direction, o_m_tdata[8:7]);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                track_word(i_s_tuser, i_s_tdata);
                s_taken = 1'b1;
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin : drive_words
        t_cover_cmd w;
        if (i_rst_n && !(i_s_tvalid && !s_taken)) begin
            s_taken = 1'b0;
            if (s_gap != 0) begin
                s_gap--;
                i_s_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                w = cmd_queue.pop_front();
                i_s_tuser <= w.cmd;
                i_s_tdata <= w.tgt;
                i_s_tvalid <= 1'b1;
                s_gap = s_eager ? 0 : $urandom_range(0, 10);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : take_reports
        if (i_rst_n) begin
            if (m_taken) begin
                m_taken = 1'b0;
                m_stall = m_eager ? 0 : $urandom_range(0, 10);
            end
            // A long hold-off lets the block fill up and push back on the sender.
            if (hold_req) begin
                hold_req = 1'b0;
                m_stall = LONG_HOLD;
            end
            if (m_stall != 0) begin
                m_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic push_word(input logic [2:0] cmd, input logic [TGT_W-1:0] tgt);
        t_cover_cmd w;
        w.cmd = cmd;
        w.tgt = tgt;
        cmd_queue.push_back(w);
        if (cmd <= CMD_STOP)
            n_queued++;
    endtask

    // Random part: an optional command with random content followed by a burst of ticks.
    task automatic push_random(input int unsigned count);
        int unsigned start;
        int unsigned r;
        int unsigned burst;
        start = n_queued;
        while (n_queued - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                push_word(CMD_TARGET, ($urandom_range(0, 3) == 0) ?
                          8'($urandom_range(101, 255)) : 8'($urandom_range(0, 100)));
            else if (r < 50)
                push_word(CMD_UP, 8'($urandom));
            else if (r < 65)
                push_word(CMD_DOWN, 8'($urandom));
            else if (r < 75)
                push_word(CMD_STOP, 8'($urandom));
            else if (r < 80)
                push_word(3'($urandom_range(5, 7)), 8'($urandom));
            else if (r < 88)
                push_word(3'($urandom), 8'($urandom));
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) :
                                                  $urandom_range(0, 25);
            repeat (burst) push_word(CMD_TICK, 8'($urandom));
        end
    endtask

    task automatic wait_drained;
        while (cmd_queue.size() != 0 || i_s_tvalid || pending_reports.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_STEP_INTERVAL)
            cfg_step = data[CNT_W-1:0];
        else
            cfg_holdoff = data[CNT_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_timing(input int unsigned step, input int unsigned holdoff);
        wait_drained();
        repeat (4) @(negedge i_clk);
        write_reg(ADDR_STEP_INTERVAL, step);
        write_reg(ADDR_REPORT_HOLDOFF, holdoff);
    endtask

    // mode bit 0: sender never idles, bit 1: receiver never stalls.
    task automatic run_phase(input int unsigned step, input int unsigned holdoff,
                             input int unsigned count, input int unsigned mode,
                             input bit with_hold);
        int unsigned half;
        set_timing(step, holdoff);
        s_eager = mode[0];
        m_eager = mode[1];
        push_random(count);
        if (with_hold) begin
            half = cmd_queue.size() / 2;
            while (cmd_queue.size() > half)
                @(negedge i_clk);
            hold_req = 1'b1;
        end
    endtask

    initial begin : run
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default timing after reset: reaching a target stops and reports at once.
        push_word(CMD_TARGET, 8'd1);
        push_word(CMD_TICK, 8'd0);
        push_word(3'd5, 8'hFF);
        push_word(3'd6, 8'h80);
        push_word(3'd7, 8'h00);

        // Step on every tick: target equal to position, above the top, clamping at zero.
        set_timing(0, 0);
        push_word(CMD_TARGET, 8'd1);
        push_word(CMD_TICK, 8'hAA);
        push_word(CMD_TARGET, 8'd255);
        repeat (3) push_word(CMD_TICK, 8'h55);
        push_word(CMD_STOP, 8'h00);
        push_word(CMD_TICK, 8'h00);
        push_word(CMD_UP, 8'hFF);
        repeat (6) push_word(CMD_TICK, 8'h00);
        push_word(CMD_TARGET, 8'd0);
        push_word(CMD_TICK, 8'h00);
        push_word(CMD_DOWN, 8'h00);
        push_word(CMD_TARGET, 8'd100);
        push_word(CMD_STOP, 8'hFF);

        run_phase(1, 0, 250, 0, 1'b0);
        run_phase(0, 5, 220, 1, 1'b1);
        run_phase(2, 20, 250, 2, 1'b0);
        run_phase(65535, 65535, 60, 3, 1'b0);
        run_phase(1, 65535, 160, 0, 1'b0);
        run_phase(3, 1, 240, 1, 1'b0);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (n_mismatch == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
